// File: rtl/awv_pkg.sv
// package for the anemometer wind vector block
// holds sizes, register indexes, state codes and the cordic angle table
// no dependencies
`default_nettype none

package awv_pkg;

	localparam int AVG_DEPTH    = 50;
	localparam int SAMPLE_BITS  = 10;
	localparam int CFG_W        = 10;
	localparam int SPD_W        = 8;
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 32;
	localparam int POS_W        = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int MEM_AW       = POS_W + 1;
	localparam int MEM_D        = 2 ** MEM_AW;
	localparam int TOT_W        = $clog2(AVG_DEPTH * ((2 ** SAMPLE_BITS) - 1) + 1);
	localparam int CP_W         = $clog2(AVG_DEPTH * ((2 ** CFG_W) - 1) + 1);
	localparam int PW           = (TOT_W > CP_W) ? TOT_W : CP_W;
	localparam int DIFF_W       = PW + 1;
	localparam int NUM_W        = PW + SPD_W + 8;
	localparam int Q_W          = NUM_W - $clog2(AVG_DEPTH + 1) + 1;
	localparam int M_W          = Q_W + 1;
	localparam int N_W          = M_W + 1;
	localparam int R_W          = M_W + 1;
	localparam int SQ_W         = 2 * R_W;
	localparam int FRAC         = 16;
	localparam int X_W          = N_W + FRAC + 2;
	localparam int Z_W          = 26;
	localparam int CORDIC_STEPS = 18;
	localparam int CI_W         = 5;
	localparam int ITER_N       = (R_W > CORDIC_STEPS) ? R_W : CORDIC_STEPS;
	localparam int CNT_MAX      = (NUM_W > ITER_N) ? NUM_W : ITER_N;
	localparam int CNT_W        = $clog2(CNT_MAX + 1);
	localparam int SPEED_W      = 12;
	localparam int DIR_W        = 9;

	localparam logic [CFG_W-1:0] RST_CALM_W  = 10'd547;
	localparam logic [CFG_W-1:0] RST_CALM_E  = 10'd581;
	localparam logic [CFG_W-1:0] RST_NORTH_W = 10'd850;
	localparam logic [CFG_W-1:0] RST_NORTH_E = 10'd226;
	localparam logic [CFG_W-1:0] RST_EAST_W  = 10'd720;
	localparam logic [CFG_W-1:0] RST_EAST_E  = 10'd712;
	localparam logic [SPD_W-1:0] RST_SPEED   = 8'd10;

	typedef enum logic [2:0] {
		REG_CALM_W,
		REG_CALM_E,
		REG_NORTH_W,
		REG_NORTH_E,
		REG_EAST_W,
		REG_EAST_E,
		REG_CALIB_SPEED
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_PREP,
		ST_DIV,
		ST_SUM,
		ST_SQN,
		ST_SQE,
		ST_ITER,
		ST_FIN
	} state_t;

	function automatic logic signed [Z_W-1:0] atan_q16(input logic [CI_W-1:0] i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			5'd0:    v = 26'sd2949120;
			5'd1:    v = 26'sd1740967;
			5'd2:    v = 26'sd919879;
			5'd3:    v = 26'sd466945;
			5'd4:    v = 26'sd234379;
			5'd5:    v = 26'sd117304;
			5'd6:    v = 26'sd58666;
			5'd7:    v = 26'sd29335;
			5'd8:    v = 26'sd14668;
			5'd9:    v = 26'sd7334;
			5'd10:   v = 26'sd3667;
			5'd11:   v = 26'sd1833;
			5'd12:   v = 26'sd917;
			5'd13:   v = 26'sd458;
			5'd14:   v = 26'sd229;
			5'd15:   v = 26'sd115;
			5'd16:   v = 26'sd57;
			5'd17:   v = 26'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/awv_if.sv
// request channels of the anemometer wind vector block
// sample channel in, result channel out; depends on awv_pkg
`default_nettype none

interface awv_in_if;
	logic                             valid;
	logic                             ready;
	logic [awv_pkg::SAMPLE_BITS-1:0]  sample;
	logic                             from_west;

	modport source (output valid, sample, from_west, input ready);
	modport sink (input valid, sample, from_west, output ready);
endinterface

interface awv_out_if;
	logic                             valid;
	logic                             ready;
	logic [awv_pkg::SPEED_W-1:0]      wind_speed;
	logic signed [awv_pkg::DIR_W-1:0] wind_direction;
	logic                             calib_error;

	modport source (output valid, wind_speed, wind_direction, calib_error, input ready);
	modport sink (input valid, wind_speed, wind_direction, calib_error, output ready);
endinterface

`default_nettype wire

// File: rtl/anemometer_wind_vector.sv
// top level of the anemometer wind vector block
// ring memory, running sums, dividers, square root and cordic; uses awv_pkg, awv_if
// Each sample request goes through these steps from acceptance to a valid result: the
// ring memory write-back (the old entry is read at the accepting edge), a set-up
// state, the four bit-serial dividers run side by side, the summing and squaring states,
// then the digit-by-digit square root with the 18-step cordic running in its shadow,
// and the load of the result register. One request is in work at a time, so a new
// request is taken only once the last one has loaded its result; a finished result
// waits in the output register while the next request is taken, and the load stalls
// while that register is still full.
// Both rings share one memory with a valid bit per entry, so no clearing pass is needed.
`default_nettype none

module anemometer_wind_vector (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [awv_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [awv_pkg::PDATA_W-1:0]  pwdata,
	output logic      [awv_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	awv_in_if.sink                            sample_ch,
	awv_out_if.source                         result_ch
);
	import awv_pkg::*;

	// configuration
	logic [CFG_W-1:0] calm_w_q, calm_e_q, north_w_q, north_e_q, east_w_q, east_e_q;
	logic [SPD_W-1:0] speed_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calm_w_q  <= RST_CALM_W;
			calm_e_q  <= RST_CALM_E;
			north_w_q <= RST_NORTH_W;
			north_e_q <= RST_NORTH_E;
			east_w_q  <= RST_EAST_W;
			east_e_q  <= RST_EAST_E;
			speed_q   <= RST_SPEED;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CALM_W:      calm_w_q  <= pwdata[CFG_W-1:0];
				REG_CALM_E:      calm_e_q  <= pwdata[CFG_W-1:0];
				REG_NORTH_W:     north_w_q <= pwdata[CFG_W-1:0];
				REG_NORTH_E:     north_e_q <= pwdata[CFG_W-1:0];
				REG_EAST_W:      east_w_q  <= pwdata[CFG_W-1:0];
				REG_EAST_E:      east_e_q  <= pwdata[CFG_W-1:0];
				REG_CALIB_SPEED: speed_q   <= pwdata[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CALM_W:      prdata = PDATA_W'(calm_w_q);
			REG_CALM_E:      prdata = PDATA_W'(calm_e_q);
			REG_NORTH_W:     prdata = PDATA_W'(north_w_q);
			REG_NORTH_E:     prdata = PDATA_W'(north_e_q);
			REG_EAST_W:      prdata = PDATA_W'(east_w_q);
			REG_EAST_E:      prdata = PDATA_W'(east_e_q);
			REG_CALIB_SPEED: prdata = PDATA_W'(speed_q);
			default:         prdata = '0;
		endcase
	end

	// control
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic res_valid_q;
	logic accept, load_res;

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept          = sample_ch.valid && (state_q == ST_IDLE);
	assign load_res        = (state_q == ST_FIN) && (!res_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_UPD;
			ST_UPD:  state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(NUM_W - 1)) state_d = ST_SUM;
			ST_SUM:  state_d = ST_SQN;
			ST_SQN:  state_d = ST_SQE;
			ST_SQE:  state_d = ST_ITER;
			ST_ITER: if (cnt_q == CNT_W'(ITER_N - 1)) state_d = ST_FIN;
			ST_FIN:  if (load_res) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((state_q == ST_DIV) || (state_q == ST_ITER)) begin
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	// ring memory, west ring in the upper half
	logic [SAMPLE_BITS-1:0] ring_mem [MEM_D];
	logic [MEM_D-1:0]       vld_q;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                   west_q;
	logic [MEM_AW-1:0]      addr_q, rd_addr;
	logic [POS_W-1:0]       west_pos_q, east_pos_q;
	logic [TOT_W-1:0]       west_tot_q, east_tot_q;
	logic [SAMPLE_BITS-1:0] old_smp;
	logic [TOT_W-1:0]       tot_cur, tot_new;
	logic [POS_W-1:0]       pos_cur, pos_nxt;

	assign rd_addr = {sample_ch.from_west,
		sample_ch.from_west ? west_pos_q : east_pos_q};

	always_ff @(posedge clk) begin
		if (accept) rd_q <= ring_mem[rd_addr];
		if (state_q == ST_UPD) ring_mem[addr_q] <= smp_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q  <= sample_ch.sample;
			west_q <= sample_ch.from_west;
			addr_q <= rd_addr;
		end
	end

	assign old_smp = vld_q[addr_q] ? rd_q : '0;
	assign tot_cur = west_q ? west_tot_q : east_tot_q;
	assign tot_new = tot_cur + TOT_W'(smp_q) - TOT_W'(old_smp);
	assign pos_cur = west_q ? west_pos_q : east_pos_q;
	assign pos_nxt = (pos_cur == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			west_pos_q <= '0;
			east_pos_q <= '0;
			west_tot_q <= '0;
			east_tot_q <= '0;
		end else if (state_q == ST_UPD) begin
			vld_q[addr_q] <= 1'b1;
			if (west_q) begin
				west_tot_q <= tot_new;
				west_pos_q <= pos_nxt;
			end else begin
				east_tot_q <= tot_new;
				east_pos_q <= pos_nxt;
			end
		end
	end

	// term set-up: lanes are north-west, north-east, east-west, east-east
	logic [CP_W-1:0]          cp_w, cp_e;
	logic signed [DIFF_W-1:0] diff_w, diff_e;
	logic [PW-1:0]            mag_w, mag_e;
	logic [PW+SPD_W-1:0]      prod_w, prod_e;
	logic [CFG_W-1:0]         cal_a [4];
	logic [CFG_W-1:0]         calm_a [4];
	logic                     nneg_a [4];
	logic signed [CFG_W:0]    d_a [4];
	logic [CFG_W-1:0]         dmag_a [4];
	logic [CP_W-1:0]          den_a [4];
	logic [CP_W-1:0]          den_q [4];
	logic                     neg_q [4];
	logic [CP_W-1:0]          rem_q [4];
	logic [NUM_W-1:0]         quo_q [4];
	logic [CP_W:0]            shf_a [4];
	logic                     err_q;

	assign cp_w   = CP_W'(calm_w_q * AVG_DEPTH);
	assign cp_e   = CP_W'(calm_e_q * AVG_DEPTH);
	assign diff_w = $signed({{(DIFF_W-TOT_W){1'b0}}, west_tot_q})
		- $signed({{(DIFF_W-CP_W){1'b0}}, cp_w});
	assign diff_e = $signed({{(DIFF_W-TOT_W){1'b0}}, east_tot_q})
		- $signed({{(DIFF_W-CP_W){1'b0}}, cp_e});
	assign mag_w  = diff_w[DIFF_W-1] ? PW'(-diff_w) : PW'(diff_w);
	assign mag_e  = diff_e[DIFF_W-1] ? PW'(-diff_e) : PW'(diff_e);
	assign prod_w = mag_w * speed_q;
	assign prod_e = mag_e * speed_q;

	assign cal_a[0]  = north_w_q;
	assign cal_a[1]  = north_e_q;
	assign cal_a[2]  = east_w_q;
	assign cal_a[3]  = east_e_q;
	assign calm_a[0] = calm_w_q;
	assign calm_a[1] = calm_e_q;
	assign calm_a[2] = calm_w_q;
	assign calm_a[3] = calm_e_q;
	assign nneg_a[0] = diff_w[DIFF_W-1];
	assign nneg_a[1] = diff_e[DIFF_W-1];
	assign nneg_a[2] = diff_w[DIFF_W-1];
	assign nneg_a[3] = diff_e[DIFF_W-1];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			d_a[l]    = $signed({1'b0, cal_a[l]}) - $signed({1'b0, calm_a[l]});
			dmag_a[l] = d_a[l][CFG_W] ? CFG_W'(-d_a[l]) : CFG_W'(d_a[l]);
			den_a[l]  = CP_W'(dmag_a[l] * AVG_DEPTH);
			shf_a[l]  = {rem_q[l], quo_q[l][NUM_W-1]};
		end
	end

	// bit-serial restoring dividers
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			err_q <= (north_w_q == calm_w_q) || (north_e_q == calm_e_q)
				|| (east_w_q == calm_w_q) || (east_e_q == calm_e_q);
			for (int l = 0; l < 4; l++) begin
				den_q[l] <= den_a[l];
				neg_q[l] <= d_a[l][CFG_W] ^ nneg_a[l];
				rem_q[l] <= '0;
			end
			quo_q[0] <= {prod_w, 8'd0};
			quo_q[1] <= {prod_e, 8'd0};
			quo_q[2] <= {prod_w, 8'd0};
			quo_q[3] <= {prod_e, 8'd0};
		end else if (state_q == ST_DIV) begin
			for (int l = 0; l < 4; l++) begin
				if (shf_a[l] >= {1'b0, den_q[l]}) begin
					rem_q[l] <= CP_W'(shf_a[l] - {1'b0, den_q[l]});
					quo_q[l] <= {quo_q[l][NUM_W-2:0], 1'b1};
				end else begin
					rem_q[l] <= shf_a[l][CP_W-1:0];
					quo_q[l] <= {quo_q[l][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	// components
	logic signed [Q_W:0]   t_a [4];
	logic signed [N_W-1:0] n_q, e_q;
	logic [M_W-1:0]        un, ue;
	logic [2*M_W-1:0]      un_sq, ue_sq;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			t_a[l] = neg_q[l] ? -$signed({1'b0, quo_q[l][Q_W-1:0]})
				: $signed({1'b0, quo_q[l][Q_W-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			n_q <= $signed({t_a[0][Q_W], t_a[0]}) + $signed({t_a[1][Q_W], t_a[1]});
			e_q <= $signed({t_a[2][Q_W], t_a[2]}) + $signed({t_a[3][Q_W], t_a[3]});
		end
	end

	assign un    = n_q[N_W-1] ? M_W'(-n_q) : M_W'(n_q);
	assign ue    = e_q[N_W-1] ? M_W'(-e_q) : M_W'(e_q);
	assign un_sq = un * un;
	assign ue_sq = ue * ue;

	// square root, two bits a step
	logic [SQ_W-1:0] sq_q, rad_q, root_q, bit_q, trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SQN) begin
			sq_q <= {2'b00, un_sq};
		end else if (state_q == ST_SQE) begin
			rad_q  <= sq_q + {2'b00, ue_sq};
			root_q <= '0;
			bit_q  <= SQ_W'(1) << (2 * (R_W - 1));
		end else if ((state_q == ST_ITER) && (cnt_q < CNT_W'(R_W))) begin
			if (rad_q >= trial) begin
				rad_q  <= rad_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// cordic vectoring
	logic signed [X_W-1:0] x_q, y_q, ex, ny, dx, dy;
	logic signed [Z_W-1:0] z_q, ang;

	assign ex  = {{(X_W-N_W-FRAC){e_q[N_W-1]}}, e_q, {FRAC{1'b0}}};
	assign ny  = {{(X_W-N_W-FRAC){n_q[N_W-1]}}, n_q, {FRAC{1'b0}}};
	assign dx  = y_q >>> cnt_q;
	assign dy  = x_q >>> cnt_q;
	assign ang = atan_q16(cnt_q[CI_W-1:0]);

	always_ff @(posedge clk) begin
		if (state_q == ST_SQN) begin
			if (!e_q[N_W-1]) begin
				x_q <= ex;
				y_q <= ny;
				z_q <= '0;
			end else if (!n_q[N_W-1]) begin
				x_q <= ny;
				y_q <= -ex;
				z_q <= Z_W'(90 << FRAC);
			end else begin
				x_q <= -ny;
				y_q <= ex;
				z_q <= -Z_W'(90 << FRAC);
			end
		end else if ((state_q == ST_ITER) && (cnt_q < CNT_W'(CORDIC_STEPS))) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
	end

	// result
	logic [R_W:0]              spd_sum;
	logic [R_W-9:0]            spd_raw;
	logic [SPEED_W-1:0]        spd;
	logic [Z_W-1:0]            z_abs;
	logic [DIR_W-1:0]          deg;
	logic signed [DIR_W-1:0]   dir;
	logic [SPEED_W-1:0]        res_speed_q;
	logic signed [DIR_W-1:0]   res_dir_q;
	logic                      res_err_q;

	assign spd_sum = {1'b0, root_q[R_W-1:0]} + (R_W+1)'(256);
	assign spd_raw = spd_sum[R_W:9];
	assign spd     = (spd_raw > (R_W-8)'(4095)) ? '1 : SPEED_W'(spd_raw);
	assign z_abs   = z_q[Z_W-1] ? Z_W'(-z_q) : Z_W'(z_q);
	assign deg     = DIR_W'(z_abs >> FRAC);

	always_comb begin
		priority if (n_q == '0) begin
			dir = e_q[N_W-1] ? 9'sd180 : 9'sd0;
		end else if (e_q == '0) begin
			dir = n_q[N_W-1] ? -9'sd90 : 9'sd90;
		end else if (un == ue) begin
			if (!e_q[N_W-1]) dir = n_q[N_W-1] ? -9'sd45 : 9'sd45;
			else dir = n_q[N_W-1] ? -9'sd135 : 9'sd135;
		end else begin
			dir = z_q[Z_W-1] ? -$signed(deg) : $signed(deg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (load_res) res_valid_q <= 1'b1;
		else if (result_ch.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_speed_q <= err_q ? '0 : spd;
			res_dir_q   <= err_q ? '0 : dir;
			res_err_q   <= err_q;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.wind_speed     = res_speed_q;
	assign result_ch.wind_direction = res_dir_q;
	assign result_ch.calib_error    = res_err_q;

endmodule

`default_nettype wire

// File: dv/anemometer_wind_vector_tb.sv
// testbench for the anemometer wind vector block
// drives sample requests and apb register writes, predicts speed and direction
// depends on awv_pkg, awv_if and the rtl top level
`timescale 1ns / 1ps

module anemometer_wind_vector_tb;
	import awv_pkg::*;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   from_west;
	} sample_req_t;

	typedef struct packed {
		logic [SPEED_W-1:0]       wind_speed;
		logic signed [DIR_W-1:0]  wind_direction;
		logic                     calib_error;
	} wind_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	awv_in_if  sample_ch ();
	awv_out_if result_ch ();

	anemometer_wind_vector dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample_ch(sample_ch.sink), .result_ch(result_ch.source)
	);

	sample_req_t pending_q[$];
	wind_res_t   wind_q[$];
	int          errors = 0;
	int          hold_off = 0;
	int          gap = 0;
	int          stall = 0;

	logic [9:0] cal [6];
	logic [7:0] cal_speed;
	logic [9:0] west_ring [AVG_DEPTH];
	logic [9:0] east_ring [AVG_DEPTH];
	int         west_pos, east_pos;
	longint     west_total, east_total;

	localparam longint ATAN_TAB [18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint fshift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -1 - ((-1 - v) >>> s);
	endfunction

	function automatic longint component(longint total, longint calm, longint point);
		longint num, den;
		num = total * 256 - calm * AVG_DEPTH * 256;
		den = (point - calm) * AVG_DEPTH;
		return (longint'(cal_speed) * num) / den;
	endfunction

	function automatic longint root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint heading(longint n, longint e);
		longint x, y, z, t, dx, dy, an, ae;
		an = n < 0 ? -n : n;
		ae = e < 0 ? -e : e;
		if (n == 0) return e < 0 ? 180 : 0;
		if (e == 0) return n > 0 ? 90 : -90;
		if (an == ae) begin
			if (e > 0) return n > 0 ? 45 : -45;
			return n > 0 ? 135 : -135;
		end
		x = e * 65536;
		y = n * 65536;
		z = 0;
		if (e < 0) begin
			if (n >= 0) begin
				t = x; x = y; y = -t; z = 90 * 65536;
			end else begin
				t = x; x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < 18; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		return z >= 0 ? (z >>> 16) : -((-z) >>> 16);
	endfunction

	function automatic wind_res_t wind_predict(sample_req_t r);
		wind_res_t res;
		longint n, e, m, spd;
		res = '0;
		if (r.from_west) begin
			west_total = west_total + r.sample - west_ring[west_pos];
			west_ring[west_pos] = r.sample;
			west_pos = (west_pos + 1 == AVG_DEPTH) ? 0 : west_pos + 1;
		end else begin
			east_total = east_total + r.sample - east_ring[east_pos];
			east_ring[east_pos] = r.sample;
			east_pos = (east_pos + 1 == AVG_DEPTH) ? 0 : east_pos + 1;
		end
		if (cal[REG_NORTH_W] == cal[REG_CALM_W] || cal[REG_NORTH_E] == cal[REG_CALM_E] ||
				cal[REG_EAST_W] == cal[REG_CALM_W] || cal[REG_EAST_E] == cal[REG_CALM_E]) begin
			res.calib_error = 1'b1;
		end else begin
			n = component(west_total, cal[REG_CALM_W], cal[REG_NORTH_W])
				+ component(east_total, cal[REG_CALM_E], cal[REG_NORTH_E]);
			e = component(west_total, cal[REG_CALM_W], cal[REG_EAST_W])
				+ component(east_total, cal[REG_CALM_E], cal[REG_EAST_E]);
			m = root(longint'((n < 0 ? -n : n) * (n < 0 ? -n : n) + (e < 0 ? -e : e) * (e < 0 ? -e : e)));
			spd = (m + 256) >>> 9;
			res.wind_speed = spd > 4095 ? 12'd4095 : spd[11:0];
			res.wind_direction = DIR_W'(heading(n, e));
		end
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_CALIB_SPEED) cal_speed = val[7:0];
		else cal[idx] = val[9:0];
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || wind_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic push(logic [9:0] s, logic w);
		sample_req_t r;
		r.sample = s;
		r.from_west = w;
		pending_q.push_back(r);
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.sample <= '0;
			sample_ch.from_west <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				wind_q.push_back(wind_predict(pending_q.pop_front()));
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (gap > 0) begin
					gap--;
					sample_ch.valid <= 1'b0;
				end else if (pending_q.size() > (sample_ch.valid && sample_ch.ready ? 0 : 0)
						&& pending_q.size() != 0) begin
					sample_ch.valid <= 1'b1;
					sample_ch.sample <= pending_q[0].sample;
					sample_ch.from_west <= pending_q[0].from_west;
					gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
						: ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (wind_q.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					wind_res_t w;
					w = wind_q.pop_front();
					if (result_ch.wind_speed !== w.wind_speed)
						report("wind_speed", 32'(result_ch.wind_speed), 32'(w.wind_speed));
					if (result_ch.wind_direction !== w.wind_direction)
						report("wind_direction", 32'(result_ch.wind_direction),
							32'(w.wind_direction));
					if (result_ch.calib_error !== w.calib_error)
						report("calib_error", 32'(result_ch.calib_error),
							32'(w.calib_error));
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				result_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
					: ($urandom_range(0, 1) ? 0 : $urandom_range(0, 4));
			end
		end
	end

	initial begin
		#50_000_000;
		$display("anemometer_wind_vector test failed");
		$finish;
	end

	initial begin
		logic [9:0] s;
		cal = '{10'd547, 10'd581, 10'd850, 10'd226, 10'd720, 10'd712};
		cal_speed = 8'd10;
		foreach (west_ring[i]) begin
			west_ring[i] = '0;
			east_ring[i] = '0;
		end
		west_pos = 0; east_pos = 0; west_total = 0; east_total = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// extremes at reset calibration
		push(10'd0, 1'b1); push(10'd1023, 1'b0); push(10'd1023, 1'b1); push(10'd0, 1'b0);
		push(10'd547, 1'b1); push(10'd581, 1'b0); push(10'h2aa, 1'b1); push(10'h155, 1'b0);
		drain();

		// large speed saturation
		reg_write(REG_CALM_W, 32'd0); reg_write(REG_CALM_E, 32'd1023);
		reg_write(REG_NORTH_W, 32'd1); reg_write(REG_NORTH_E, 32'd1022);
		reg_write(REG_EAST_W, 32'd1023); reg_write(REG_EAST_E, 32'd0);
		reg_write(REG_CALIB_SPEED, 32'hffff_ffff);
		for (int i = 0; i < 8; i++) push(10'd1023, i[0]);
		drain();

		// zero calibration denominator, wide pwdata bits
		reg_write(REG_NORTH_W, 32'hffff_fc00);
		reg_write(REG_CALIB_SPEED, 32'd0);
		push(10'd300, 1'b1); push(10'd700, 1'b0);
		drain();
		reg_write(REG_NORTH_W, 32'd2);
		push(10'd5, 1'b1);
		drain();

		// hold off the result side while samples keep coming
		hold_off = 600;
		for (int i = 0; i < 6; i++) push(10'($urandom), 1'($urandom));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int k = 0; k < 6; k++) reg_write(reg_idx_t'(k), $urandom_range(0, 1023));
			reg_write(REG_CALIB_SPEED, ph == 0 ? 255 : $urandom_range(0, 255));
			if (ph == 1) reg_write(REG_EAST_E, 32'(cal[REG_CALM_E]));
			for (int i = 0; i < 190; i++) begin
				s = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
					: 10'($urandom);
				push(s, 1'($urandom));
			end
			drain();
		end

		if (errors == 0) begin
			$display("anemometer_wind_vector test passed");
		end else begin
			$display("anemometer_wind_vector test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/awv_pkg.sv
rtl/awv_if.sv
rtl/anemometer_wind_vector.sv
dv/anemometer_wind_vector_tb.sv
